/* hdl/ikrt_pkg.sv */
package ikrt_pkg;

	localparam int DEPTH         = 16;
	localparam int ID_WIDTH      = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [ID_WIDTH-1:0] ID_MAX = {ID_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_MODIFY = 2'd2,
		OP_GET    = 2'd3
	} op_e;

	typedef logic [ID_WIDTH-1:0]      id_t;
	typedef logic [PAYLOAD_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// Request token handed from cell to cell, collecting the outcome.
	typedef struct packed {
		logic  active;
		logic  done;
		op_e   op;
		id_t   key;
		data_t data;
		id_t   new_id;
		idx_t  pos;
		idx_t  hit;
		data_t rd;
	} token_t;

endpackage

/* hdl/ikrt_if.sv */
interface ikrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] key_id;
	logic [31:0] payload;

	modport source (output valid, output op, output key_id, output payload, input ready);
	modport sink   (input valid, input op, input key_id, input payload, output ready);
endinterface

interface ikrt_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [3:0]  slot;
	logic [15:0] id_out;
	logic [31:0] payload_out;

	modport source (output valid, output status, output slot, output id_out,
		output payload_out, input ready);
	modport sink   (input valid, input status, input slot, input id_out,
		input payload_out, output ready);
endinterface

/* hdl/ikrt_cell.sv */
module ikrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ikrt_pkg::token_t tin,
	output ikrt_pkg::token_t tout
);
	import ikrt_pkg::*;

	logic   valid_q;
	id_t    id_q;
	data_t  payload_q;
	token_t nxt;
	token_t tok_q;
	logic   hit_ins;
	logic   hit_lk;

	always_comb begin
		hit_ins = tin.active && !tin.done && (tin.op == OP_INSERT) && !valid_q;
		hit_lk  = tin.active && !tin.done && (tin.op != OP_INSERT) && valid_q
			&& (id_q == tin.key);
		nxt     = tin;
		nxt.pos = tin.pos + 1'b1;
		if (hit_ins || hit_lk) begin
			nxt.done = 1'b1;
			nxt.hit  = tin.pos;
			if (tin.op == OP_GET) begin
				nxt.rd = payload_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit_ins) begin
			valid_q <= 1'b1;
		end else if (hit_lk && (tin.op == OP_DELETE)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_ins) begin
			id_q      <= tin.new_id;
			payload_q <= tin.data;
		end else if (hit_lk) begin
			case (tin.op)
				OP_MODIFY: payload_q <= tin.data;
				default: ;
			endcase
		end
	end

	// Hand the token to the next cell every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
		end
	end

	assign tout = tok_q;

endmodule

/* hdl/id_keyed_record_table_unit.sv */
// Record table with automatic ids, built as a row of DEPTH slot cells.
// req channel: op (insert, delete, modify, get), key_id and payload. An insert
// takes the lowest free slot and the next id (1 upward, wrapping to 1); the
// other operations act on the lowest valid slot holding key_id.
// rsp channel: one item per request with status (0 ok, 1 error), slot,
// id_out and payload_out (payload only on a successful get).
// A request enters cell 0 in the cycle it is accepted and moves one cell per
// cycle through the row; its response is registered once it leaves the last cell.
// One request is in the row at a time; the next is accepted only once the
// response is registered, so the table never takes a new request before it
// is through with the last one.
// If the receiver stalls, the response waits in the output register while the
// next request walks the row; a finished result that finds the output still
// full is parked until the output is taken.
// Reset clears every slot's valid bit and the id counter, and empties the
// row and the output register. Ready is high again right after reset.
module id_keyed_record_table_unit (
	input logic       clk,
	input logic       arst_n,
	ikrt_req_if.sink  req,
	ikrt_rsp_if.source rsp
);
	import ikrt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t state_q;
	token_t chain [DEPTH+1];
	token_t inj;
	token_t fin_q;
	token_t res;
	id_t    next_id_q;
	logic   rsp_valid_q;
	logic   status_q;
	logic [3:0]  slot_q;
	logic [15:0] id_out_q;
	logic [31:0] payload_out_q;
	logic   out_free;
	logic   exit_active;
	logic   load_out;

	always_comb begin
		inj        = '0;
		inj.active = req.valid && req.ready;
		inj.op     = op_e'(req.op);
		inj.key    = ID_WIDTH'(req.key_id);
		inj.data   = PAYLOAD_WIDTH'(req.payload);
		inj.new_id = (next_id_q == ID_MAX) ? id_t'(1) : next_id_q + 1'b1;
	end

	assign chain[0] = inj;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ikrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[i]),
			.tout   (chain[i+1])
		);
	end

	assign exit_active = chain[DEPTH].active;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign res         = (state_q == ST_HOLD) ? fin_q : chain[DEPTH];
	assign req.ready   = (state_q == ST_IDLE);
	assign load_out    = ((state_q == ST_RUN && exit_active) || state_q == ST_HOLD)
		&& out_free;

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && exit_active && !out_free) begin
			fin_q <= chain[DEPTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			next_id_q     <= '0;
			status_q      <= 1'b0;
			slot_q        <= '0;
			id_out_q      <= '0;
			payload_out_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (exit_active) begin
						if (chain[DEPTH].done && chain[DEPTH].op == OP_INSERT) begin
							next_id_q <= chain[DEPTH].new_id;
						end
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Load the result once it leaves the row and the output is free.
			if (load_out) begin
				rsp_valid_q   <= 1'b1;
				status_q      <= !res.done;
				slot_q        <= res.done ? 4'(res.hit) : 4'd0;
				id_out_q      <= !res.done ? 16'd0
					: (res.op == OP_INSERT) ? 16'(res.new_id) : 16'(res.key);
				payload_out_q <= (res.done && res.op == OP_GET) ? 32'(res.rd) : 32'd0;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.slot        = slot_q;
	assign rsp.id_out      = id_out_q;
	assign rsp.payload_out = payload_out_q;

endmodule

/* tb/sv/ikrt_table_checker.sv */
`timescale 1ns / 100ps

module ikrt_table_checker (
	input  logic          clk,
	input  logic          arst_n,
	ikrt_req_if           req,
	ikrt_rsp_if           rsp,
	output int unsigned   fail_count,
	output int unsigned   outstanding,
	output int unsigned   results_seen,
	output ikrt_pkg::id_t last_id
);
	import ikrt_pkg::*;

	typedef struct packed {
		logic       status;
		logic [3:0] slot;
		id_t        id;
		data_t      payload;
	} access_result_t;

	access_result_t expected_results[$];

	logic  slot_live [DEPTH];
	id_t   slot_id   [DEPTH];
	data_t slot_data [DEPTH];

	// Apply one access to the shadow table and return what the block should answer.
	task automatic predict_access(input op_e op, input id_t key, input data_t data,
		output access_result_t res);
		int hit;
		res = '0;
		res.status = 1'b1;
		hit = -1;
		if (op == OP_INSERT) begin
			for (int i = 0; i < DEPTH; i++)
				if (hit < 0 && !slot_live[i])
					hit = i;
			if (hit >= 0) begin
				last_id = (last_id == ID_MAX) ? id_t'(1) : id_t'(last_id + 1'b1);
				slot_live[hit] = 1'b1;
				slot_id[hit]   = last_id;
				slot_data[hit] = data;
				res.status     = 1'b0;
				res.slot       = 4'(hit);
				res.id         = last_id;
			end
		end else begin
			for (int i = 0; i < DEPTH; i++)
				if (hit < 0 && slot_live[i] && slot_id[i] == key)
					hit = i;
			if (hit >= 0) begin
				res.status = 1'b0;
				res.slot   = 4'(hit);
				res.id     = key;
				case (op)
					OP_DELETE: begin
						slot_live[hit] = 1'b0;
					end
					OP_MODIFY: begin
						slot_data[hit] = data;
					end
					default: begin
						res.payload = slot_data[hit];
					end
				endcase
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		access_result_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_live[i] = 1'b0;
			last_id = '0;
			expected_results.delete();
			fail_count   = 0;
			outstanding  = 0;
			results_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected result, status %0b slot %0d id %0h payload %0h",
						$time, rsp.status, rsp.slot, rsp.id_out, rsp.payload_out);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp.status));
					compare_field("slot", 32'(want.slot), 32'(rsp.slot));
					compare_field("id_out", 32'(want.id), 32'(rsp.id_out));
					compare_field("payload_out", 32'(want.payload), 32'(rsp.payload_out));
				end
			end
			if (req.valid && req.ready) begin
				predict_access(op_e'(req.op), id_t'(req.key_id), data_t'(req.payload), fresh);
				expected_results.push_back(fresh);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

/* tb/sv/tb_id_keyed_record_table_unit.sv */
`timescale 1ns / 100ps

module tb_id_keyed_record_table_unit;
	import ikrt_pkg::*;

	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;

	ikrt_req_if req_ch();
	ikrt_rsp_if rsp_ch();

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned results_seen;
	id_t         newest_id;

	int src_idle_pct;
	int sink_stall_pct;
	int holds_asked;
	int holds_served;

	id_keyed_record_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ikrt_table_checker table_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.last_id      (newest_id)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Response side: random stalls, plus a long hold-off whenever one is asked for.
	initial begin : sink_proc
		int held;
		rsp_ch.ready = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				rsp_ch.ready <= 1'b0;
				for (held = 1; held < LONG_HOLD; held++)
					@(negedge clk);
				holds_served++;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_access(input op_e op, input id_t key, input data_t data);
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.key_id  <= key;
		req_ch.payload <= data;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Keys mostly land on recently issued ids so lookups hit live records.
	task automatic send_random_access();
		int   pick;
		op_e  op;
		id_t  key;
		pick = $urandom_range(99);
		key  = newest_id - id_t'($urandom_range(0, 20));
		if (pick < 32)
			op = OP_INSERT;
		else if (pick < 62)
			op = OP_DELETE;
		else if (pick < 77)
			op = OP_MODIFY;
		else
			op = OP_GET;
		if ($urandom_range(19) == 0)
			key = ($urandom_range(3) == 0) ? id_t'(0) : id_t'($urandom());
		send_access(op, key, data_t'($urandom()));
	endtask

	task automatic run_random(input int count, input int src_pct, input int sink_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) send_random_access();
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	initial begin : stimulus
		req_ch.valid   = 1'b0;
		req_ch.op      = OP_INSERT;
		req_ch.key_id  = '0;
		req_ch.payload = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		holds_asked    = 0;
		arst_n         = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, key zero, fill to full, overflow, lookups, reuse of a freed slot
		send_access(OP_GET, '0, '0);
		send_access(OP_DELETE, 16'd1, '0);
		for (int i = 0; i < DEPTH; i++)
			send_access(OP_INSERT, ~id_t'(i),
				(i == 0) ? data_t'(0) : (i == 1) ? '1 : data_t'($urandom()));
		send_access(OP_INSERT, 16'h0001, 32'hDEAD_BEEF);
		send_access(OP_GET, 16'd16, '0);
		send_access(OP_GET, 16'd1, '0);
		send_access(OP_MODIFY, 16'd8, 32'hFFFF_FFFF);
		send_access(OP_GET, 16'd8, '0);
		send_access(OP_DELETE, 16'd5, '0);
		send_access(OP_DELETE, 16'd5, '0);
		send_access(OP_INSERT, '0, 32'h1234_5678);
		send_access(OP_GET, 16'd17, '0);
		send_access(OP_MODIFY, 16'hFFFF, '0);

		run_random(100, 0, 0);
		run_random(100, 81, 0);
		drain();
		run_random(100, 0, 81);

		// stall the output while items keep coming so the input backs up
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		holds_asked++;
		repeat (8) send_random_access();
		run_random(100, 18, 18);
		drain();

		// one more short round of each idle and stall mix
		run_random(30, 0, 0);
		run_random(30, 81, 0);
		run_random(30, 0, 81);
		run_random(30, 18, 18);

		drain();
		repeat (DEPTH + 8) @(posedge clk);
		$display("Covered %0d accesses: empty and full table, missing ids, key zero,",
			results_seen);
		$display("slot reuse, a long output stall and idle/stall mixes.");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#(5_000_000);
		$display("Run timed out with %0d results still expected", outstanding);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
